// ===== rtl/lookahead_stereo_peak_limiter_core_assert.svh =====
// Assertion macros for the lookahead stereo peak limiter
`ifndef LOOKAHEAD_STEREO_PEAK_LIMITER_CORE_ASSERT_SVH
`define LOOKAHEAD_STEREO_PEAK_LIMITER_CORE_ASSERT_SVH
`define LSPL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LSPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/lspl_pkg.sv =====
// Shared types and constants for the lookahead stereo peak limiter
`default_nettype none
package lspl_pkg;
    localparam int SW = 24;
    localparam int GW = 25;
    localparam logic [GW-1:0] UNITY = 25'h1000000;
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;
    localparam logic [1:0] REG_CEILING  = 2'd0;
    localparam logic [1:0] REG_RELEASE  = 2'd1;
    localparam logic [1:0] REG_LOOKAHEAD = 2'd2;
    localparam logic [1:0] REG_WSTEP    = 2'd3;

    typedef struct packed {
        logic start;
        logic push;
        logic emit;
        logic recover;
        logic scan_rd;
        logic scan_eval;
        logic div_start;
        logic cand_apply;
        logic scan_next;
        logic out_start;
        logic out_step;
    } t_cmd;

    typedef struct packed {
        logic emit_due;
        logic scan_more;
        logic exceeds;
        logic div_done;
        logic out_done;
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/lspl_datapath.sv =====
// Ring buffers, gain scan, divider and output scaling for the limiter
`default_nettype none
module lspl_datapath #(
    parameter int BUFFER_DEPTH = 256,
    parameter int AW = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire lspl_pkg::t_cmd  i_cmd,
    output lspl_pkg::t_stat      o_stat,
    input  wire                  i_cfg_we,
    input  wire [1:0]            i_cfg_idx,
    input  wire [23:0]           i_cfg_data,
    input  wire                  i_opcode,
    input  wire signed [23:0]    i_left_in,
    input  wire signed [23:0]    i_right_in,
    input  wire [15:0]           i_volume,
    output logic signed [23:0]   o_left_out,
    output logic signed [23:0]   o_right_out,
    output logic [24:0]          o_limit_gain
);
    import lspl_pkg::*;
    localparam int CW = AW + 1;
    localparam int XW = (CW > 9) ? CW : 9;
    localparam logic [CW-1:0] DEPTH = CW'(BUFFER_DEPTH);

    logic [22:0] r_ceiling;
    logic [23:0] r_release, r_wstep;
    logic [7:0]  r_look;
    logic [47:0] frame_mem [BUFFER_DEPTH];
    logic [22:0] peak_mem [BUFFER_DEPTH];
    logic [AW-1:0] r_rp, r_pos;
    logic [CW-1:0] r_fill;
    logic [GW-1:0] r_gain;
    logic r_op;
    logic [23:0] r_l, r_r;
    logic [15:0] r_vol;
    logic [XW-1:0] r_cnt, r_a;
    logic [22:0] r_pk;
    logic [38:0] r_p;
    logic [47:0] r_fr;
    logic [33:0] r_dec;
    // divider
    logic [63:0] r_num;
    logic [38:0] r_den;
    logic [24:0] r_q;
    logic [5:0]  r_dcnt;
    logic        r_dbusy;
    // output
    logic [1:0]  r_ost;
    logic [24:0] r_t;
    logic [23:0] r_lo, r_ro;
    logic [23:0] r_olo, r_oro;
    logic [24:0] r_og;

    function automatic logic [23:0] mag24(input logic [23:0] s);
        return s[23] ? (24'd0 - s) : s;
    endfunction

    logic [23:0] ml, mr, mx;
    logic [AW-1:0] wptr;
    logic [CW-1:0] wsum;
    always_comb begin
        ml = mag24(r_l);
        mr = mag24(r_r);
        mx = (ml > mr) ? ml : mr;
        wsum = CW'(r_rp) + r_fill;
        wptr = (wsum >= DEPTH) ? AW'(wsum - DEPTH) : AW'(wsum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= 23'h7FFFFF;
            r_release <= 24'd3495;
            r_look    <= 8'd240;
            r_wstep   <= 24'd69905;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CEILING:   r_ceiling <= i_cfg_data[22:0];
                REG_RELEASE:   r_release <= i_cfg_data;
                REG_LOOKAHEAD: r_look    <= i_cfg_data[7:0];
                REG_WSTEP:     r_wstep   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op <= i_opcode; r_l <= i_left_in; r_r <= i_right_in; r_vol <= i_volume;
        end
        if (i_cmd.push && r_fill < DEPTH) begin
            frame_mem[wptr] <= {r_l, r_r};
            peak_mem[wptr]  <= mx[23] ? 23'h7FFFFF : mx[22:0];
        end
        if (i_cmd.scan_rd) r_pk <= peak_mem[r_pos];
        if (i_cmd.out_start) r_fr <= frame_mem[r_rp];
    end

    logic [48:0] rec_prod;
    logic [49:0] red_prod;
    logic [24:0] wgt, cand;
    logic [63:0] div_diff;
    always_comb begin
        rec_prod = 49'((UNITY - r_gain) * r_release);
        wgt = (r_dec >= 34'(UNITY)) ? 25'd0 : 25'(34'(UNITY) - r_dec);
        red_prod = 50'((UNITY - r_q) * wgt) + 50'(UNITY - 25'd1);
        cand = UNITY - 25'(red_prod >> 24);
        div_diff = r_num - {1'b0, r_den, 24'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= '0; r_fill <= '0; r_gain <= UNITY; r_dbusy <= 1'b0; r_ost <= '0;
            r_olo <= '0; r_oro <= '0; r_og <= UNITY;
        end else begin
            if (i_cmd.push && r_fill < DEPTH) r_fill <= r_fill + 1'b1;
            if (i_cmd.recover) begin
                r_gain <= r_gain + 25'(rec_prod >> 24);
                r_cnt <= (XW'(r_look) + XW'(1) > XW'(r_fill)) ? XW'(r_fill)
                                                               : XW'(r_look) + XW'(1);
                r_a <= '0; r_pos <= r_rp; r_dec <= '0;
            end
            if (i_cmd.scan_eval) r_p <= 39'(r_pk * r_vol);
            if (i_cmd.div_start) begin
                r_num <= {2'b00, r_ceiling, 39'd0};
                r_den <= r_p; r_q <= '0; r_dcnt <= 6'd0; r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                // restoring division, one quotient bit per cycle, 25 bits
                if (r_num[63:24] >= {1'b0, r_den}) begin
                    r_num <= {div_diff[62:0], 1'b0};
                    r_q <= {r_q[23:0], 1'b1};
                end else begin
                    r_num <= {r_num[62:0], 1'b0};
                    r_q <= {r_q[23:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == 6'd24) r_dbusy <= 1'b0;
            end
            if (i_cmd.cand_apply && cand < r_gain) r_gain <= cand;
            if (i_cmd.scan_next) begin
                r_a <= r_a + XW'(1);
                r_pos <= (r_pos == AW'(BUFFER_DEPTH - 1)) ? '0 : r_pos + 1'b1;
                r_dec <= r_dec + 34'(r_wstep);
            end
            if (i_cmd.out_start) begin
                r_ost <= 2'd0;
            end else if (i_cmd.out_step) begin
                r_ost <= r_ost + 2'd1;
            end
            if (i_cmd.emit) begin
                r_rp <= (r_rp == AW'(BUFFER_DEPTH - 1)) ? '0 : r_rp + 1'b1;
                r_fill <= r_fill - 1'b1;
                r_olo <= r_lo;
                r_oro <= r_ro;
                r_og  <= r_gain;
            end
        end
    end

    // output: t = round(mag*vol/2^15), m = round(t*g/2^24), one multiply per step
    logic [23:0] smag;
    logic [39:0] tprod;
    logic [64:0] mprod;
    logic [40:0] mr41;
    logic [23:0] sres;
    logic [23:0] ssrc;
    always_comb begin
        ssrc  = r_ost[1] ? r_fr[23:0] : r_fr[47:24];
        smag  = mag24(ssrc);
        tprod = 40'(smag * r_vol) + 40'd16384;
        mprod = 65'(r_t * r_gain) + 65'd8388608;
        mr41  = 41'(mprod >> 24);
        if (ssrc[23]) sres = (mr41 > 41'h800000) ? 24'h800000 : 24'd0 - mr41[23:0];
        else          sres = (mr41 > 41'h7FFFFF) ? 24'h7FFFFF : mr41[23:0];
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_step) begin
            if (!r_ost[0]) r_t <= 25'(tprod >> 15);
            else if (!r_ost[1]) r_lo <= sres;
            else r_ro <= sres;
        end
    end

    // step order: t left, left result, t right, right result
    always_comb begin
        o_stat.emit_due  = (r_op == OP_DRAIN) ? (r_fill != '0)
                         : (r_fill > CW'(r_look));
        o_stat.scan_more = (r_a < r_cnt);
        o_stat.exceeds   = (r_p > {r_ceiling, 15'd0});
        o_stat.div_done  = !r_dbusy && !i_cmd.div_start;
        o_stat.out_done  = (r_ost == 2'd3);
    end
    assign o_left_out  = r_olo;
    assign o_right_out = r_oro;
    assign o_limit_gain = r_og;
endmodule
`default_nettype wire

// ===== rtl/lspl_ctrl.sv =====
// Sequencing controller for the limiter
`default_nettype none
module lspl_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    output logic                 o_valid,
    input  wire                  i_ready,
    input  wire                  i_is_push,
    output lspl_pkg::t_cmd       o_cmd,
    input  wire lspl_pkg::t_stat i_stat
);
    import lspl_pkg::*;
    localparam logic [3:0] S_IDLE = 4'd0, S_PUSH = 4'd1, S_CHK = 4'd2, S_REC = 4'd3,
                           S_RD = 4'd4, S_EV = 4'd5, S_TST = 4'd6, S_DIV = 4'd7,
                           S_APP = 4'd8, S_OUT = 4'd9, S_OUT2 = 4'd10, S_RES = 4'd11;
    logic [3:0] r_st, n_st;
    logic r_push, r_ov, n_ov;

    always_comb begin
        n_st = r_st; n_ov = r_ov;
        o_cmd = '0;
        o_ready = (r_st == S_IDLE);
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_st)
            S_IDLE: if (i_valid && o_ready) begin o_cmd.start = 1'b1; n_st = S_PUSH; end
            S_PUSH: begin o_cmd.push = r_push; n_st = S_CHK; end
            S_CHK:  n_st = i_stat.emit_due ? S_REC : S_IDLE;
            S_REC:  begin o_cmd.recover = 1'b1; n_st = S_RD; end
            S_RD:   if (i_stat.scan_more) begin o_cmd.scan_rd = 1'b1; n_st = S_EV; end
                    else begin o_cmd.out_start = 1'b1; n_st = S_OUT; end
            S_EV:   begin o_cmd.scan_eval = 1'b1; n_st = S_TST; end
            S_TST:  if (i_stat.exceeds) begin o_cmd.div_start = 1'b1; n_st = S_DIV; end
                    else begin o_cmd.scan_next = 1'b1; n_st = S_RD; end
            S_DIV:  if (i_stat.div_done) n_st = S_APP;
            S_APP:  begin o_cmd.cand_apply = 1'b1; o_cmd.scan_next = 1'b1; n_st = S_RD; end
            S_OUT:  begin o_cmd.out_step = 1'b1; n_st = S_OUT2; end
            S_OUT2: begin o_cmd.out_step = 1'b1; n_st = i_stat.out_done ? S_RES : S_OUT2; end
            S_RES:  if (!r_ov) begin o_cmd.emit = 1'b1; n_ov = 1'b1; n_st = S_IDLE; end
            default: n_st = S_IDLE;
        endcase
    end
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_push <= 1'b0;
        end else begin
            r_st <= n_st; r_ov <= n_ov;
            if (o_cmd.start) r_push <= i_is_push;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/lookahead_stereo_peak_limiter_core.sv =====
// Top level of the lookahead stereo peak limiter
// channel | direction | handshake               | payload
// input   | in        | i_valid / o_ready       | opcode, left, right, volume
// output  | out       | o_valid / i_ready       | left, right, limit gain
// config  | in        | i_cfg_we                | i_cfg_idx, i_cfg_data
// A push that emits nothing passes S_IDLE, S_PUSH and S_CHK; an emitting item scans N = min(L+1, fill)
// peaks in the peak scan loop and runs the bit-serial divider once per exceeding peak.
// Reset is synchronous and clears pointers, fill count and gain; rings are not cleared.
// One item is in work at a time; a result held in the output register for i_ready stalls
// the next emitting item in S_RES, and no input transfer is taken meanwhile.
`default_nettype none
module lookahead_stereo_peak_limiter_core #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire               i_opcode,
    input  wire signed [23:0] i_left_in,
    input  wire signed [23:0] i_right_in,
    input  wire [15:0]        i_volume,
    output logic              o_valid,
    input  wire               i_ready,
    output logic signed [23:0] o_left_out,
    output logic signed [23:0] o_right_out,
    output logic [24:0]       o_limit_gain,
    input  wire               i_cfg_we,
    input  wire [1:0]         i_cfg_idx,
    input  wire [23:0]        i_cfg_data
);
    import lspl_pkg::*;
    localparam int AW = $clog2(BUFFER_DEPTH);
    t_cmd  cmd;
    t_stat stat;

    lspl_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_is_push(i_opcode == OP_PUSH), .o_cmd(cmd), .i_stat(stat)
    );
    lspl_datapath #(.BUFFER_DEPTH(BUFFER_DEPTH), .AW(AW)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat), .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .i_opcode, .i_left_in, .i_right_in, .i_volume,
        .o_left_out, .o_right_out, .o_limit_gain
    );

`include "lookahead_stereo_peak_limiter_core_assert.svh"
    `LSPL_ASSERT_NEXT(a_no_repeat, i_clk, i_rst_n, o_valid && i_ready, !o_valid, "result repeated")
    `LSPL_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_left_out), "result lost")
    `LSPL_ASSERT_IMPL(a_gain_range, i_clk, i_rst_n, 1'b1, o_limit_gain <= UNITY, "gain above unity")
endmodule
`default_nettype wire

// ===== tb/sv/lookahead_stereo_peak_limiter_core_checker.sv =====
// Checker for the lookahead stereo peak limiter: tracks transfers, predicts output frames, compares
`default_nettype none
module lookahead_stereo_peak_limiter_core_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  wire               i_in_ready,
    input  wire               i_opcode,
    input  wire [23:0]        i_left_in,
    input  wire [23:0]        i_right_in,
    input  wire [15:0]        i_volume,
    input  wire               i_out_valid,
    input  wire               i_ready,
    input  wire [23:0]        i_left_out,
    input  wire [23:0]        i_right_out,
    input  wire [24:0]        i_limit_gain,
    input  wire               i_cfg_we,
    input  wire [1:0]         i_cfg_idx,
    input  wire [23:0]        i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_result_count
);
    import lspl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;
    localparam logic [63:0] ONE = 64'd16777216;

    typedef struct packed {
        logic [23:0] left;
        logic [23:0] right;
        logic [24:0] gain;
    } t_frame;

    t_frame      due_frames[$];
    logic [23:0] left_ring [DEPTH];
    logic [23:0] right_ring[DEPTH];
    logic [22:0] peak_ring [DEPTH];
    logic [7:0]  rd_ptr;
    logic [8:0]  fill;
    logic [24:0] gain_now;
    logic [22:0] ceil_reg;
    logic [23:0] rel_reg;
    logic [7:0]  look_reg;
    logic [23:0] wstep_reg;

    task automatic report(input string what, input logic [24:0] got, input logic [24:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        o_fail_count++;
    endtask

    function automatic logic [23:0] magnitude(input logic [23:0] s);
        if (s[23]) return 24'(25'h1000000 - {1'b0, s});
        return s;
    endfunction

    function automatic logic [23:0] scale_sample(input logic [23:0] s, input logic [15:0] vol,
                                                 input logic [24:0] g);
        logic [63:0] mag, t, m;
        mag = {40'd0, magnitude(s)};
        t = (mag * vol + 64'd16384) >> 15;
        m = (t * g + 64'd8388608) >> 24;
        if (s[23]) begin
            if (m > 64'd8388608) m = 64'd8388608;
            return 24'(64'd16777216 - m);
        end
        if (m > 64'd8388607) m = 64'd8388607;
        return m[23:0];
    endfunction

    function automatic void emit_frame(input logic [15:0] vol);
        logic [63:0] g, cnt, lim, p, r, dec, w, red, cand;
        logic [7:0]  pos;
        t_frame      f;
        g = {39'd0, gain_now};
        g = g + (((ONE - g) * rel_reg) >> 24);
        cnt = look_reg + 64'd1;
        if (cnt > fill) cnt = fill;
        lim = {41'd0, ceil_reg} << 15;
        pos = rd_ptr;
        for (int a = 0; a < cnt; a++) begin
            p = peak_ring[pos] * vol;
            if (p > lim) begin
                r = ({41'd0, ceil_reg} << 39) / p;
                dec = a * wstep_reg;
                w = (dec >= ONE) ? 64'd0 : ONE - dec;
                red = ((ONE - r) * w + ONE - 64'd1) >> 24;
                cand = ONE - red;
                if (cand < g) g = cand;
            end
            pos++;
        end
        gain_now = g[24:0];
        f.left = scale_sample(left_ring[rd_ptr], vol, gain_now);
        f.right = scale_sample(right_ring[rd_ptr], vol, gain_now);
        f.gain = gain_now;
        due_frames.push_back(f);
        rd_ptr++;
        fill--;
    endfunction

    function automatic void limiter_step(input logic op, input logic [23:0] l,
                                         input logic [23:0] r, input logic [15:0] vol);
        logic [23:0] ml, mr, pk;
        logic [7:0]  wr;
        if (op == OP_PUSH) begin
            if (fill < DEPTH) begin
                wr = rd_ptr + fill[7:0];
                left_ring[wr] = l;
                right_ring[wr] = r;
                ml = magnitude(l);
                mr = magnitude(r);
                pk = (ml > mr) ? ml : mr;
                if (pk > 24'h7fffff) pk = 24'h7fffff;
                peak_ring[wr] = pk[22:0];
                fill++;
            end
            if (fill > look_reg) emit_frame(vol);
        end else if (fill != 0) begin
            emit_frame(vol);
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
    end

    always @(posedge i_clk) begin
        t_frame want;
        if (!i_rst_n) begin
            due_frames.delete();
            rd_ptr = '0;
            fill = '0;
            gain_now = UNITY;
            ceil_reg = 23'd8388607;
            rel_reg = 24'd3495;
            look_reg = 8'd240;
            wstep_reg = 24'd69905;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CEILING:   ceil_reg = i_cfg_data[22:0];
                    REG_RELEASE:   rel_reg = i_cfg_data;
                    REG_LOOKAHEAD: look_reg = i_cfg_data[7:0];
                    REG_WSTEP:     wstep_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_ready) begin
                o_result_count++;
                if (due_frames.size() == 0) begin
                    report("unexpected transfer", i_limit_gain, 25'd0);
                end else begin
                    want = due_frames.pop_front();
                    if (i_left_out !== want.left)   report("left", i_left_out, want.left);
                    if (i_right_out !== want.right) report("right", i_right_out, want.right);
                    if (i_limit_gain !== want.gain) report("gain", i_limit_gain, want.gain);
                end
            end
            if (i_valid && i_in_ready) limiter_step(i_opcode, i_left_in, i_right_in, i_volume);
        end
        o_pending = due_frames.size();
    end
endmodule
`default_nettype wire

// ===== tb/sv/lookahead_stereo_peak_limiter_core_test.sv =====
// Testbench top for the lookahead stereo peak limiter: stimulus, configuration and verdict
`default_nettype none
module lookahead_stereo_peak_limiter_core_test;
    import lspl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 60000;
    localparam int SETTLE = 9000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_opcode = OP_PUSH;
    logic signed [23:0] i_left_in = '0;
    logic signed [23:0] i_right_in = '0;
    logic [15:0]        i_volume = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [23:0] o_left_out;
    logic signed [23:0] o_right_out;
    logic [24:0]        o_limit_gain;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = REG_CEILING;
    logic [23:0]        i_cfg_data = '0;

    int fail_count, pending, result_count;
    int pushes = 0, drains = 0, idle_cycles = 0;
    bit no_gaps = 0, no_stalls = 0, hold_req = 0;

    lookahead_stereo_peak_limiter_core uut (.*);

    lookahead_stereo_peak_limiter_core_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_ready(o_ready),
        .i_opcode(i_opcode), .i_left_in(i_left_in), .i_right_in(i_right_in),
        .i_volume(i_volume), .i_out_valid(o_valid), .i_ready(i_ready),
        .i_left_out(o_left_out), .i_right_out(o_right_out), .i_limit_gain(o_limit_gain),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = no_stalls ? 0 : $urandom_range(0, 8);
            if (hold_req) begin
                stall = 3000;
                hold_req = 0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    task automatic send(input logic op, input logic [23:0] l, input logic [23:0] r,
                        input logic [15:0] vol);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_opcode <= op;
        i_left_in <= l;
        i_right_in <= r;
        i_volume <= vol;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (op == OP_PUSH) pushes++;
        else drains++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(input logic [22:0] ceil_v, input logic [23:0] rel_v,
                             input logic [7:0] look_v, input logic [23:0] wstep_v);
        logic [23:0] vals[4];
        vals = '{{1'b0, ceil_v}, rel_v, {16'd0, look_v}, wstep_v};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 2'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'($signed($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] rand_volume();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hffff;
            2: return 16'd32768;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero lookahead: each push leaves at once
        configure(23'd4000000, 24'd3495, 8'd0, 24'd8388608);
        send(OP_PUSH, 24'h800000, 24'h7fffff, 16'hffff);
        send(OP_PUSH, 24'h000000, 24'hffffff, 16'd0);
        send(OP_PUSH, 24'h800000, 24'h800000, 16'hffff);
        send(OP_DRAIN, 24'h0, 24'h0, 16'd32768);
        settle();

        // lowered lookahead leaves frames behind for the drains
        configure(23'd0, 24'hffffff, 8'd4, 24'd0);
        for (int k = 0; k < 6; k++) send(OP_PUSH, rand_sample(), rand_sample(), rand_volume());
        settle();
        configure(23'h7fffff, 24'd0, 8'd1, 24'hffffff);
        send(OP_PUSH, 24'h7fffff, 24'h800000, 16'hffff);
        send(OP_PUSH, 24'h123456, 24'h876543, 16'd32768);
        for (int k = 0; k < 5; k++) send(OP_DRAIN, 24'hffffff, 24'h0, rand_volume());
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            logic [22:0] c;
            logic [23:0] rl, ws;
            logic [7:0]  la;
            c = 23'($urandom());
            rl = 24'($urandom_range(0, 200000));
            ws = 24'($urandom());
            la = 8'($urandom_range(1, 16));
            if (ph == 0) begin
                c = 23'd0; rl = 24'd0; ws = 24'd0; la = 8'd1;
            end else if (ph == 1) begin
                c = 23'h7fffff; rl = 24'hffffff; ws = 24'hffffff; la = 8'd16;
            end
            configure(c, rl, la, ws);
            no_gaps = (ph == 3);
            no_stalls = (ph == 3);
            for (int k = 0; k < 50; k++) begin
                if (ph == 2 && k == 20) hold_req = 1;
                if ($urandom_range(0, 99) < 85)
                    send(OP_PUSH, rand_sample(), rand_sample(), rand_volume());
                else
                    send(OP_DRAIN, 24'($urandom()), 24'($urandom()), rand_volume());
            end
            no_gaps = 0;
            no_stalls = 0;
            settle();
        end

        // deepest lookahead: fill the ring, then drain it past empty
        configure(23'h7fffff, 24'd3495, 8'd255, 24'd65793);
        for (int k = 0; k < 258; k++) begin
            if (k % 64 == 10)
                send(OP_PUSH, 24'h800000, rand_sample(), 16'($urandom_range(32769, 65535)));
            else
                send(OP_PUSH, 24'($signed($urandom_range(0, 4000)) - 2000),
                     24'($urandom() >> 12), 16'($urandom_range(0, 32768)));
        end
        for (int k = 0; k < 260; k++) send(OP_DRAIN, 24'h0, 24'h0, 16'($urandom_range(0, 32768)));
        settle();

        $display("covered %0d pushes and %0d drains over 9 register settings, %0d frames out",
                 pushes, drains, result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
